>>> hw/rtl/aklpd_pkg.sv
// ----------------------------------------------------------------------------
// ADC ladder key press detector package
// Shared widths, key and register codes, reset values and payload types.
// ----------------------------------------------------------------------------
package aklpd_pkg;

  localparam int unsigned AdcW     = 12;
  localparam int unsigned KeyW     = 3;
  localparam int unsigned CntW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned NumTh    = 8;

  // Key codes
  localparam logic [KeyW-1:0] KeyNone   = 3'd0;
  localparam logic [KeyW-1:0] KeyPlay   = 3'd1;
  localparam logic [KeyW-1:0] KeyRecord = 3'd2;
  localparam logic [KeyW-1:0] KeyFeed   = 3'd3;
  localparam logic [KeyW-1:0] KeyTime   = 3'd4;
  localparam logic [KeyW-1:0] KeySet    = 3'd5;
  localparam logic [KeyW-1:0] KeyDown   = 3'd6;
  localparam logic [KeyW-1:0] KeyUp     = 3'd7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgThNonePlay   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgThRecordFeed = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgThTimeSet    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgThDownUp     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLongTicks    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgShortTicks   = 3'd5;

  // Configuration reset values
  localparam logic [CfgDataW-1:0] RstThNonePlay   = 24'd15568100;
  localparam logic [CfgDataW-1:0] RstThRecordFeed = 24'd11471100;
  localparam logic [CfgDataW-1:0] RstThTimeSet    = 24'd7374100;
  localparam logic [CfgDataW-1:0] RstThDownUp     = 24'd3277100;
  localparam logic [CntW-1:0]     RstLongTicks    = 8'd100;
  localparam logic [CntW-1:0]     RstShortTicks   = 8'd3;

  // Thresholds in priority order: none, play, record, feed, time, set, down, up
  typedef logic [NumTh-1:0][AdcW-1:0] thresh_t;

  // Press timing limits
  typedef struct packed {
    logic [CntW-1:0] long_ticks;
    logic [CntW-1:0] short_ticks;
  } limits_t;

  // One result transaction
  typedef struct packed {
    logic [KeyW-1:0] key_now;
    logic [KeyW-1:0] event_key;
    logic            short_press;
    logic            long_press;
  } result_t;

  // Key queue handshake seen from the back end
  typedef struct packed {
    logic            empty;
    logic [KeyW-1:0] key;
  } key_q_stat_t;

endpackage

>>> hw/rtl/aklpd_front.sv
// ----------------------------------------------------------------------------
// ADC ladder key press detector front end
// Classifies each accepted ADC sample against the threshold ladder and
// stores the key code in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module aklpd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aklpd_pkg::thresh_t            thresh_i,
  input  logic                          push_i,
  input  logic [aklpd_pkg::AdcW-1:0]    adc_sample_i,
  output logic                          full_o,
  input  logic                          key_pop_i,
  output aklpd_pkg::key_q_stat_t        key_stat_o
);

  logic [aklpd_pkg::KeyW-1:0] key_cls;
  logic [aklpd_pkg::KeyW-1:0] mem_q [2];
  logic                       wr_ptr_q, wr_ptr_d;
  logic                       rd_ptr_q, rd_ptr_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic                       do_push, do_pop;

  // Pick the first threshold that the sample reaches; below all is no key
  always_comb begin
    key_cls = aklpd_pkg::KeyNone;
    for (int i = aklpd_pkg::NumTh - 1; i >= 0; i--) begin
      if (adc_sample_i >= thresh_i[i]) begin
        key_cls = aklpd_pkg::KeyW'(i);
      end
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = key_pop_i && (cnt_q != 2'd0);

  // Advance queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store classified key
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= key_cls;
    end
  end

  assign key_stat_o.empty = (cnt_q == 2'd0);
  assign key_stat_o.key   = mem_q[rd_ptr_q];

endmodule

>>> hw/rtl/aklpd_back.sv
// ----------------------------------------------------------------------------
// ADC ladder key press detector back end
// Tracks the held key, hold count and press flags, and queues one result
// transaction per key code in a two-entry output queue.
// ----------------------------------------------------------------------------
module aklpd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  aklpd_pkg::limits_t         limits_i,
  input  aklpd_pkg::key_q_stat_t     key_stat_i,
  output logic                       key_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output aklpd_pkg::result_t         result_o
);

  logic [aklpd_pkg::KeyW-1:0] prev_key_q, prev_key_d;
  logic [aklpd_pkg::CntW-1:0] hold_cnt_q, hold_cnt_d;
  logic [aklpd_pkg::CntW-1:0] hold_inc;
  logic                       short_q, short_d;
  logic                       long_q, long_d;
  logic [aklpd_pkg::KeyW-1:0] rep_key_q, rep_key_d;
  logic [aklpd_pkg::KeyW-1:0] key;
  logic                       step;

  aklpd_pkg::result_t         res;
  aklpd_pkg::result_t         mem_q [2];
  logic                       wr_ptr_q, rd_ptr_q;
  logic [1:0]                 cnt_q, cnt_d;
  logic                       do_pop;

  assign key       = key_stat_i.key;
  assign step      = !key_stat_i.empty && (cnt_q != 2'd2);
  assign key_pop_o = step;
  assign hold_inc  = hold_cnt_q + 8'd1;

  // Update press state for the next key code
  always_comb begin
    hold_cnt_d = hold_cnt_q;
    short_d    = short_q;
    long_d     = long_q;
    rep_key_d  = rep_key_q;
    if (prev_key_q == aklpd_pkg::KeyNone && key != aklpd_pkg::KeyNone) begin
      hold_cnt_d = '0;
      short_d    = 1'b0;
      long_d     = 1'b0;
      rep_key_d  = aklpd_pkg::KeyNone;
    end else if (key == prev_key_q && key != aklpd_pkg::KeyNone) begin
      hold_cnt_d = hold_inc;
      if (hold_inc == limits_i.long_ticks) begin
        short_d   = 1'b0;
        long_d    = 1'b1;
        rep_key_d = prev_key_q;
      end
    end else if (key == aklpd_pkg::KeyNone && prev_key_q != aklpd_pkg::KeyNone) begin
      if (hold_cnt_q < limits_i.long_ticks && hold_cnt_q > limits_i.short_ticks) begin
        hold_cnt_d = '0;
        short_d    = 1'b1;
        long_d     = 1'b0;
        rep_key_d  = prev_key_q;
      end
    end else begin
      hold_cnt_d = '0;
      short_d    = 1'b0;
      long_d     = 1'b0;
      rep_key_d  = aklpd_pkg::KeyNone;
    end
    prev_key_d = key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_key_q <= aklpd_pkg::KeyNone;
      hold_cnt_q <= '0;
      short_q    <= 1'b0;
      long_q     <= 1'b0;
      rep_key_q  <= aklpd_pkg::KeyNone;
    end else if (step) begin
      prev_key_q <= prev_key_d;
      hold_cnt_q <= hold_cnt_d;
      short_q    <= short_d;
      long_q     <= long_d;
      rep_key_q  <= rep_key_d;
    end
  end

  // Build result from the updated state
  always_comb begin
    res.key_now     = key;
    res.event_key   = rep_key_d;
    res.short_press = short_d;
    res.long_press  = long_d;
  end

  assign do_pop = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (step && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !step) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Advance output queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ step;
      rd_ptr_q <= rd_ptr_q ^ do_pop;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued results
  always_ff @(posedge clk_i) begin
    if (step) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

  assign empty_o  = (cnt_q == 2'd0);
  assign result_o = mem_q[rd_ptr_q];

endmodule

>>> hw/rtl/adc_ladder_key_press_detector_top.sv
// ----------------------------------------------------------------------------
// ADC ladder key press detector top level
// Configuration registers, front end classifier and back end press tracker.
// ----------------------------------------------------------------------------
// The block takes one ADC sample per clock cycle while full_o is low and
// returns one result per sample. A pushed sample is classified into the key
// queue; the press tracker takes it once its output queue has room and
// registers the result there. The rate is set by the press tracker's state
// update, which handles one key code per cycle while one is waiting and the
// output queue has room. Two-entry queues on both sides let input and result
// sides stall independently without losing throughput. Write configuration
// only while no results are outstanding.
module adc_ladder_key_press_detector_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aklpd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [aklpd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [aklpd_pkg::AdcW-1:0]        adc_sample_i,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic [aklpd_pkg::KeyW-1:0]        key_now_o,
  output logic [aklpd_pkg::KeyW-1:0]        event_key_o,
  output logic                              short_press_o,
  output logic                              long_press_o
);

  logic [aklpd_pkg::CfgDataW-1:0] th_np_q, th_rf_q, th_ts_q, th_du_q;
  logic [aklpd_pkg::CntW-1:0]     long_q, short_q;
  aklpd_pkg::thresh_t             thresh;
  aklpd_pkg::limits_t             limits;
  aklpd_pkg::key_q_stat_t         key_stat;
  aklpd_pkg::result_t             result;
  logic                           key_pop;

  // Write configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_np_q <= aklpd_pkg::RstThNonePlay;
      th_rf_q <= aklpd_pkg::RstThRecordFeed;
      th_ts_q <= aklpd_pkg::RstThTimeSet;
      th_du_q <= aklpd_pkg::RstThDownUp;
      long_q  <= aklpd_pkg::RstLongTicks;
      short_q <= aklpd_pkg::RstShortTicks;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aklpd_pkg::CfgThNonePlay:   th_np_q <= cfg_wdata_i;
        aklpd_pkg::CfgThRecordFeed: th_rf_q <= cfg_wdata_i;
        aklpd_pkg::CfgThTimeSet:    th_ts_q <= cfg_wdata_i;
        aklpd_pkg::CfgThDownUp:     th_du_q <= cfg_wdata_i;
        aklpd_pkg::CfgLongTicks:    long_q  <= cfg_wdata_i[aklpd_pkg::CntW-1:0];
        aklpd_pkg::CfgShortTicks:   short_q <= cfg_wdata_i[aklpd_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack thresholds in priority order
  assign thresh[0] = th_np_q[23:12];
  assign thresh[1] = th_np_q[11:0];
  assign thresh[2] = th_rf_q[23:12];
  assign thresh[3] = th_rf_q[11:0];
  assign thresh[4] = th_ts_q[23:12];
  assign thresh[5] = th_ts_q[11:0];
  assign thresh[6] = th_du_q[23:12];
  assign thresh[7] = th_du_q[11:0];

  assign limits.long_ticks  = long_q;
  assign limits.short_ticks = short_q;

  aklpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thresh_i     (thresh),
    .push_i       (push_i),
    .adc_sample_i (adc_sample_i),
    .full_o       (full_o),
    .key_pop_i    (key_pop),
    .key_stat_o   (key_stat)
  );

  aklpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limits_i   (limits),
    .key_stat_i (key_stat),
    .key_pop_o  (key_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .result_o   (result)
  );

  assign key_now_o     = result.key_now;
  assign event_key_o   = result.event_key;
  assign short_press_o = result.short_press;
  assign long_press_o  = result.long_press;

endmodule

>>> tb/aklpd_press_checker.sv
// ----------------------------------------------------------------------------
// ADC ladder key press detector checker
// Watches the configuration port and both queue sides. It predicts every
// result from the accepted samples and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module aklpd_press_checker
  import aklpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push_i,
  input  logic                full_i,
  input  logic [AdcW-1:0]     adc_sample_i,
  input  logic                pop_i,
  input  logic                empty_i,
  input  logic [KeyW-1:0]     key_now_i,
  input  logic [KeyW-1:0]     event_key_i,
  input  logic                short_press_i,
  input  logic                long_press_i,
  output int                  pending_o,
  output int                  errors_o
);

  // Shadow configuration
  thresh_t         ladder_th;
  logic [CntW-1:0] long_ticks;
  logic [CntW-1:0] short_ticks;

  // Shadow press tracker state
  logic [KeyW-1:0] last_key;
  logic [CntW-1:0] hold_cnt;
  logic            short_flg;
  logic            long_flg;
  logic [KeyW-1:0] press_key;

  result_t expected_reports[$];
  int      err_cnt;

  // Load one threshold register: high half first in priority order
  task automatic load_pair(input int unsigned n, input logic [CfgDataW-1:0] data);
    ladder_th[2*n]   = data[23:12];
    ladder_th[2*n+1] = data[11:0];
  endtask

  // Classify the sample and advance the press tracker by one tick
  task automatic advance_tracker(input logic [AdcW-1:0] sample, output result_t res);
    logic [KeyW-1:0] key;
    logic            found;
    key   = KeyNone;
    found = 1'b0;
    for (int i = 0; i < NumTh; i++) begin
      if (!found && sample >= ladder_th[i]) begin
        key   = KeyW'(i);
        found = 1'b1;
      end
    end
    if (last_key == KeyNone && key != KeyNone) begin
      // fresh press
      hold_cnt  = '0;
      short_flg = 1'b0;
      long_flg  = 1'b0;
      press_key = KeyNone;
    end else if (key == last_key && key != KeyNone) begin
      // held: count with wrap, flag long press on the limit
      hold_cnt = hold_cnt + CntW'(1);
      if (hold_cnt == long_ticks) begin
        short_flg = 1'b0;
        long_flg  = 1'b1;
        press_key = last_key;
      end
    end else if (key == KeyNone && last_key != KeyNone) begin
      // release: short press only strictly inside the window
      if (hold_cnt < long_ticks && hold_cnt > short_ticks) begin
        hold_cnt  = '0;
        short_flg = 1'b1;
        long_flg  = 1'b0;
        press_key = last_key;
      end
    end else begin
      // idle or key change
      hold_cnt  = '0;
      short_flg = 1'b0;
      long_flg  = 1'b0;
      press_key = KeyNone;
    end
    last_key        = key;
    res.key_now     = key;
    res.event_key   = press_key;
    res.short_press = short_flg;
    res.long_press  = long_flg;
  endtask

  task automatic compare_field(input string name, input logic [KeyW-1:0] want,
                               input logic [KeyW-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      load_pair(0, RstThNonePlay);
      load_pair(1, RstThRecordFeed);
      load_pair(2, RstThTimeSet);
      load_pair(3, RstThDownUp);
      long_ticks  = RstLongTicks;
      short_ticks = RstShortTicks;
      last_key    = KeyNone;
      hold_cnt    = '0;
      short_flg   = 1'b0;
      long_flg    = 1'b0;
      press_key   = KeyNone;
      expected_reports.delete();
      err_cnt     = 0;
    end else begin
      // track register writes; unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgThNonePlay:   load_pair(0, cfg_wdata_i);
          CfgThRecordFeed: load_pair(1, cfg_wdata_i);
          CfgThTimeSet:    load_pair(2, cfg_wdata_i);
          CfgThDownUp:     load_pair(3, cfg_wdata_i);
          CfgLongTicks:    long_ticks = cfg_wdata_i[CntW-1:0];
          CfgShortTicks:   short_ticks = cfg_wdata_i[CntW-1:0];
          default: ;
        endcase
      end
      // compare the popped result with the oldest expectation
      if (pop_i && !empty_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t mismatch: result with none expected, actual %0d/%0d/%0b/%0b",
                   $time, key_now_i, event_key_i, short_press_i, long_press_i);
          err_cnt++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("key_now", want.key_now, key_now_i);
          compare_field("event_key", want.event_key, event_key_i);
          compare_field("short_press", KeyW'(want.short_press), KeyW'(short_press_i));
          compare_field("long_press", KeyW'(want.long_press), KeyW'(long_press_i));
        end
      end
      // predict the result of each accepted sample
      if (push_i && !full_i) begin
        advance_tracker(adc_sample_i, fresh);
        expected_reports.push_back(fresh);
      end
    end
    pending_o <= expected_reports.size();
    errors_o  <= err_cnt;
  end

endmodule

>>> tb/tb_adc_ladder_key_press_detector_top.sv
// ----------------------------------------------------------------------------
// ADC ladder key press detector testbench
// Drives directed and random keypad sample streams under several threshold
// and press limit settings, with random stalls on both queue sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_adc_ladder_key_press_detector_top;
  import aklpd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;
  localparam int unsigned NumPhases = 6;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                push_i;
  logic                full_o;
  logic [AdcW-1:0]     adc_sample_i;
  logic                pop_i;
  logic                empty_o;
  logic [KeyW-1:0]     key_now_o;
  logic [KeyW-1:0]     event_key_o;
  logic                short_press_o;
  logic                long_press_o;

  int pending_cnt;
  int error_cnt;
  int cycle_cnt = 0;
  int samples_sent = 0;
  bit calm = 1'b0;

  // Testbench copy of the programmed settings, used to aim samples at keys
  logic [AdcW-1:0] lad_th [NumTh];
  logic [CntW-1:0] long_lim;
  logic [CntW-1:0] short_lim;

  always #4 clk_i = ~clk_i;

  adc_ladder_key_press_detector_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push_i),
    .full_o       (full_o),
    .adc_sample_i (adc_sample_i),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .key_now_o    (key_now_o),
    .event_key_o  (event_key_o),
    .short_press_o(short_press_o),
    .long_press_o (long_press_o)
  );

  aklpd_press_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push_i),
    .full_i       (full_o),
    .adc_sample_i (adc_sample_i),
    .pop_i        (pop_i),
    .empty_i      (empty_o),
    .key_now_i    (key_now_o),
    .event_key_i  (event_key_o),
    .short_press_i(short_press_o),
    .long_press_i (long_press_o),
    .pending_o    (pending_cnt),
    .errors_o     (error_cnt)
  );

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: pop with random stall bursts
  initial begin
    pop_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        pop_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Push one sample and hold it until the block takes it
  task automatic send_sample(input logic [AdcW-1:0] s);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push_i       <= 1'b1;
    adc_sample_i <= s;
    do @(posedge clk_i); while (full_o);
    samples_sent++;
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain, then write every register and mirror the settings
  task automatic program_ladder(input logic [CfgDataW-1:0] none_play, record_feed,
                                input logic [CfgDataW-1:0] time_set, down_up,
                                input logic [CfgDataW-1:0] long_data, short_data);
    drain();
    write_reg(CfgThNonePlay, none_play);
    write_reg(CfgThRecordFeed, record_feed);
    write_reg(CfgThTimeSet, time_set);
    write_reg(CfgThDownUp, down_up);
    write_reg(CfgLongTicks, long_data);
    write_reg(CfgShortTicks, short_data);
    lad_th[0] = none_play[23:12];
    lad_th[1] = none_play[11:0];
    lad_th[2] = record_feed[23:12];
    lad_th[3] = record_feed[11:0];
    lad_th[4] = time_set[23:12];
    lad_th[5] = time_set[11:0];
    lad_th[6] = down_up[23:12];
    lad_th[7] = down_up[11:0];
    long_lim  = long_data[CntW-1:0];
    short_lim = short_data[CntW-1:0];
  endtask

  // Pick a sample near the threshold of the wanted key
  function automatic logic [AdcW-1:0] ladder_sample_for(input int k);
    int v;
    if (k == KeyNone) begin
      if (lad_th[NumTh-1] != 0 && $urandom_range(0, 1) == 1)
        v = $urandom_range(0, lad_th[NumTh-1] - 1);
      else
        v = $urandom_range(lad_th[0], 4095);
    end else begin
      v = lad_th[k] + $urandom_range(0, 15);
    end
    if (v > 4095) v = 4095;
    return v[AdcW-1:0];
  endfunction

  initial begin
    logic [AdcW-1:0] t [NumTh];
    logic [AdcW-1:0] s;
    int              start_cnt;
    int              budget;
    int              k;
    int              len;
    int              r;

    rst_ni       = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CfgThNonePlay;
    cfg_wdata_i  <= '0;
    push_i       <= 1'b0;
    adc_sample_i <= '0;
    lad_th[0] = RstThNonePlay[23:12];
    lad_th[1] = RstThNonePlay[11:0];
    lad_th[2] = RstThRecordFeed[23:12];
    lad_th[3] = RstThRecordFeed[11:0];
    lad_th[4] = RstThTimeSet[23:12];
    lad_th[5] = RstThTimeSet[11:0];
    lad_th[6] = RstThDownUp[23:12];
    lad_th[7] = RstThDownUp[11:0];
    long_lim  = RstLongTicks;
    short_lim = RstShortTicks;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: sample extremes, each key edge, short press on release
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd299);
    repeat (6) send_sample(12'd300);
    send_sample(12'd0);
    repeat (2) send_sample(12'd3300);
    send_sample(12'd2800);
    send_sample(12'd2300);
    send_sample(12'd1800);
    send_sample(12'd1300);
    send_sample(12'd800);
    send_sample(12'd3799);
    send_sample(12'd3800);

    // Unknown indexes are ignored; only the low byte of the limits counts
    drain();
    write_reg(CfgUnusedLo, 24'($urandom));
    write_reg(CfgUnusedHi, 24'($urandom));
    program_ladder(RstThNonePlay, RstThRecordFeed, RstThTimeSet, RstThDownUp,
                   24'hABCD03, 24'h5A5A00);

    // Long press, then release past the window, then idle
    repeat (5) send_sample(12'd1300);
    send_sample(12'd0);
    send_sample(12'd0);

    // Random phases, each under its own settings
    for (int phase = 0; phase < NumPhases; phase++) begin
      for (int i = 0; i < NumTh; i++)
        t[i] = AdcW'(4095 - i * 500 - $urandom_range(0, 450));
      budget = 330;
      case (phase)
        0: program_ladder(RstThNonePlay, RstThRecordFeed, RstThTimeSet, RstThDownUp,
                          24'(RstLongTicks), 24'(RstShortTicks));
        1: program_ladder({t[0], t[1]}, {t[2], t[3]}, {t[4], t[5]}, {t[6], t[7]},
                          {16'($urandom), 8'd255}, {16'($urandom), 8'd254});
        2: program_ladder({t[0], t[1]}, {t[2], t[3]}, {t[4], t[5]}, {t[6], t[7]},
                          24'd0, 24'd0);
        3: begin
          budget = 60;
          program_ladder(24'd0, 24'd0, 24'd0, 24'd0, 24'd5, 24'd1);
        end
        4: begin
          // out of order thresholds below a top no-key threshold
          len = $urandom_range(1, 20);
          program_ladder(24'($urandom) | 24'hFFF000, 24'($urandom), 24'($urandom),
                         24'($urandom), 24'(len), 24'($urandom_range(0, len)));
        end
        default: begin
          calm = 1'b1;
          program_ladder({t[0], t[1]}, {t[2], t[3]}, {t[4], t[5]}, {t[6], t[7]},
                         24'd8, 24'd2);
        end
      endcase
      start_cnt = samples_sent;
      while (samples_sent - start_cnt < budget) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          // press, hold around the limits, release
          k = $urandom_range(1, 7);
          case ($urandom_range(0, 9))
            0:       len = $urandom_range(250, 300);
            1, 2, 3: len = $urandom_range(0, 8);
            default: len = $urandom_range(short_lim, long_lim + 2);
          endcase
          s = ladder_sample_for(k);
          repeat (len + 1) begin
            if ($urandom_range(0, 7) == 0) send_sample(ladder_sample_for(k));
            else send_sample(s);
          end
          repeat ($urandom_range(1, 3)) send_sample(ladder_sample_for(KeyNone));
        end else if (r == 7) begin
          // jump from key to key
          repeat ($urandom_range(1, 5)) send_sample(ladder_sample_for($urandom_range(1, 7)));
        end else begin
          repeat ($urandom_range(1, 4)) send_sample(AdcW'($urandom_range(0, 4095)));
        end
      end
    end

    drain();
    if (error_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/aklpd_pkg.sv
hw/rtl/aklpd_front.sv
hw/rtl/aklpd_back.sv
hw/rtl/adc_ladder_key_press_detector_top.sv
tb/aklpd_press_checker.sv
tb/tb_adc_ladder_key_press_detector_top.sv
